FILE: rtl/stream_find_and_replace_assert.svh
// Assertion macros shared by the modules of the find-and-replace block.
// Every macro samples on the rising edge of clk and is disabled while rst is high.
`ifndef STREAM_FIND_AND_REPLACE_ASSERT_SVH
`define STREAM_FIND_AND_REPLACE_ASSERT_SVH

// A property that must hold at every clock edge.
`define SFR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A condition that must be followed by another one in the next cycle.
`define SFR_ASSERT_NEXT(label, cond, nxt, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (nxt)) else $error(msg);

`endif

FILE: rtl/sfr_pkg.sv
`default_nettype none

package sfr_pkg;

  localparam int DATA_W = 64;
  localparam int LEN_W  = 4;
  localparam int ADDR_W = 5;

  localparam logic [1:0] REG_PATTERN_BYTES     = 2'd0;
  localparam logic [1:0] REG_PATTERN_LENGTH    = 2'd1;
  localparam logic [1:0] REG_REPLACEMENT_BYTES = 2'd2;
  localparam logic [1:0] REG_REPLACEMENT_LEN   = 2'd3;

  // Settings as the engine sees them: lengths already clamped to their legal range.
  typedef struct packed {
    logic [DATA_W-1:0] pattern;
    logic [LEN_W-1:0]  plen;
    logic [DATA_W-1:0] repl;
    logic [LEN_W-1:0]  rlen;
    logic              clear;
  } cfg_t;

endpackage

`default_nettype wire

FILE: rtl/sfr_if.sv
`default_nettype none

interface sfr_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       text_last;

  modport source (output valid, output text_byte, output text_last, input ready);
  modport sink (input valid, input text_byte, input text_last, output ready);
endinterface

interface sfr_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_valid;
  logic       out_last;

  modport source (output valid, output out_byte, output out_valid, output out_last,
                  input ready);
  modport sink (input valid, input out_byte, input out_valid, input out_last,
                output ready);
endinterface

`default_nettype wire

FILE: rtl/sfr_cmp.sv
`default_nettype none

// Compares the first m window bytes against the start of the pattern.
module sfr_cmp
  import sfr_pkg::*;
#(
  parameter int PATTERN_MAX = 8
) (
  input  wire logic [7:0]        win [PATTERN_MAX],
  input  wire logic [DATA_W-1:0] pattern,
  input  wire logic [LEN_W-1:0]  m,
  output logic                   match
);

  logic [PATTERN_MAX-1:0] eq;

  always_comb begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      eq[i] = (LEN_W'(i) >= m) || (win[i] == pattern[8*i +: 8]);
    end
  end

  assign match = &eq;

endmodule

`default_nettype wire

FILE: rtl/sfr_regs.sv
`default_nettype none

module sfr_regs
  import sfr_pkg::*;
#(
  parameter int PATTERN_MAX = 8,
  parameter int REPLACE_MAX = 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  logic [DATA_W-1:0] pattern_bytes;
  logic [LEN_W-1:0]  pattern_length;
  logic [DATA_W-1:0] replacement_bytes;
  logic [LEN_W-1:0]  replacement_length;
  logic              wr;
  logic [1:0]        idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[4:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes      <= '0;
      pattern_length     <= LEN_W'(1);
      replacement_bytes  <= '0;
      replacement_length <= '0;
    end else if (wr) begin
      case (idx)
        REG_PATTERN_BYTES:     pattern_bytes      <= pwdata;
        REG_PATTERN_LENGTH:    pattern_length     <= pwdata[LEN_W-1:0];
        REG_REPLACEMENT_BYTES: replacement_bytes  <= pwdata;
        REG_REPLACEMENT_LEN:   replacement_length <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_PATTERN_BYTES:     prdata = pattern_bytes;
      REG_PATTERN_LENGTH:    prdata = DATA_W'(pattern_length);
      REG_REPLACEMENT_BYTES: prdata = replacement_bytes;
      REG_REPLACEMENT_LEN:   prdata = DATA_W'(replacement_length);
      default:               prdata = '0;
    endcase
  end

  always_comb begin
    cfg.pattern = pattern_bytes;
    cfg.repl    = replacement_bytes;
    if (pattern_length == '0) begin
      cfg.plen = LEN_W'(1);
    end else if (pattern_length > LEN_W'(PATTERN_MAX)) begin
      cfg.plen = LEN_W'(PATTERN_MAX);
    end else begin
      cfg.plen = pattern_length;
    end
    if (replacement_length > LEN_W'(REPLACE_MAX)) begin
      cfg.rlen = LEN_W'(REPLACE_MAX);
    end else begin
      cfg.rlen = replacement_length;
    end
    // A new pattern makes the held bytes meaningless, so they are dropped.
    cfg.clear = wr && (idx == REG_PATTERN_BYTES || idx == REG_PATTERN_LENGTH);
  end

endmodule

`default_nettype wire

FILE: rtl/sfr_engine.sv
`default_nettype none

`include "stream_find_and_replace_assert.svh"

module sfr_engine
  import sfr_pkg::*;
#(
  parameter int PATTERN_MAX = 8,
  parameter int REPLACE_MAX = 8
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire cfg_t  cfg,
  sfr_text_if.sink   text,
  sfr_result_if.source result
);

  localparam int IDX_W  = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int RIDX_W = (REPLACE_MAX > 1) ? $clog2(REPLACE_MAX) : 1;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CHECK = 2'd1;
  localparam logic [1:0] ST_REPL  = 2'd2;
  localparam logic [1:0] ST_FLUSH = 2'd3;

  logic [1:0]        state, state_next;
  logic [7:0]        win [PATTERN_MAX];
  logic [LEN_W-1:0]  cnt, cnt_next;
  logic [LEN_W-1:0]  n;
  logic              last_r;
  logic [RIDX_W-1:0] ridx, ridx_next;
  logic              ridx_last;

  logic              ov;
  logic [7:0]        ob;
  logic              ovld;
  logic              olast;

  logic              slot_free;
  logic              match;
  logic              full;
  logic              load;
  logic              shift;
  logic              emit;
  logic [7:0]        e_byte;
  logic              e_vld;
  logic              e_last;

  sfr_cmp #(
    .PATTERN_MAX(PATTERN_MAX)
  ) u_cmp (
    .win    (win),
    .pattern(cfg.pattern),
    .m      (cnt),
    .match  (match)
  );

  assign slot_free  = !ov || result.ready;
  assign full       = match && (cnt == cfg.plen);
  assign text.ready = (state == ST_IDLE);
  assign n          = (cfg.clear || cnt >= cfg.plen) ? '0 : cnt;
  assign ridx_last  = ({{(LEN_W-RIDX_W){1'b0}}, ridx} + LEN_W'(1)) == cfg.rlen;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    ridx_next  = ridx;
    load       = 1'b0;
    shift      = 1'b0;
    emit       = 1'b0;
    e_byte     = win[0];
    e_vld      = 1'b1;
    e_last     = 1'b0;
    case (state)
      ST_IDLE: begin
        if (cfg.clear) begin
          cnt_next = '0;
        end
        if (text.valid) begin
          load       = 1'b1;
          cnt_next   = n + LEN_W'(1);
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (full) begin
          cnt_next   = '0;
          ridx_next  = '0;
          state_next = ST_REPL;
        end else if (last_r) begin
          // Nothing can match any more: the whole window goes out in order.
          state_next = ST_FLUSH;
        end else if (match) begin
          state_next = ST_IDLE;
        end else if (slot_free) begin
          // The head byte cannot start a match; send it and try the next alignment.
          emit     = 1'b1;
          shift    = 1'b1;
          cnt_next = cnt - LEN_W'(1);
        end
      end
      ST_REPL: begin
        if (cfg.rlen == '0) begin
          if (!last_r) begin
            state_next = ST_IDLE;
          end else if (slot_free) begin
            emit       = 1'b1;
            e_byte     = '0;
            e_vld      = 1'b0;
            e_last     = 1'b1;
            state_next = ST_IDLE;
          end
        end else if (slot_free) begin
          emit      = 1'b1;
          e_byte    = cfg.repl[{ridx, 3'b000} +: 8];
          e_last    = last_r && ridx_last;
          ridx_next = ridx + RIDX_W'(1);
          if (ridx_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_FLUSH: begin
        if (slot_free) begin
          emit     = 1'b1;
          shift    = 1'b1;
          e_last   = (cnt == LEN_W'(1));
          cnt_next = cnt - LEN_W'(1);
          if (cnt == LEN_W'(1)) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      ov    <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (emit) begin
        ov <= 1'b1;
      end else if (result.ready) begin
        ov <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ridx <= ridx_next;
    if (load) begin
      win[n[IDX_W-1:0]] <= text.text_byte;
      last_r            <= text.text_last;
    end
    if (shift) begin
      for (int i = 0; i < PATTERN_MAX - 1; i++) begin
        win[i] <= win[i+1];
      end
    end
    if (emit) begin
      ob    <= e_byte;
      ovld  <= e_vld;
      olast <= e_last;
    end
  end

  assign result.valid     = ov;
  assign result.out_byte  = ob;
  assign result.out_valid = ovld;
  assign result.out_last  = olast;

  `SFR_ASSERT(a_cnt_bound, cnt <= LEN_W'(PATTERN_MAX), "window count beyond its depth")
  `SFR_ASSERT(a_flush_nonempty, state != ST_FLUSH || cnt != '0, "flush with an empty window")
  `SFR_ASSERT(a_marker_final, !ov || ovld || olast, "empty marker beat not marked last")
  `SFR_ASSERT_NEXT(a_accept_check, text.valid && text.ready, state == ST_CHECK,
                   "accepted byte not followed by a window check")

endmodule

`default_nettype wire

FILE: rtl/stream_find_and_replace.sv
`default_nettype none

// Streaming literal find-and-replace. Text enters one byte per beat on the text channel, and every
// leftmost, non-overlapping occurrence of the programmed pattern (1 to 8 bytes) is replaced by the
// programmed replacement (0 to 8 bytes); all other bytes leave unchanged and in order on the result
// channel, one byte per beat. Up to pattern_length-1 bytes that may still start a match are held
// back. The beat with text_last flushes them and carries out_last on the final result; if it yields
// no character, a single beat with out_valid 0 and out_last 1 marks the end. A new byte is accepted
// only while the engine is idle, after the previous byte has been checked and every byte it released
// or every replacement byte has been sent. The engine has a single window comparator, which checks
// one alignment per cycle while the output slot is free, and a one-deep output register, which sends
// one byte per cycle while the result channel is ready.
// Registers sit at byte addresses 0, 8, 16 and 24 on the 64-bit APB port. Writing the pattern or
// its length drops the held bytes; program the block only while it is idle.
module stream_find_and_replace
  import sfr_pkg::*;
#(
  parameter int PATTERN_MAX = 8,
  parameter int REPLACE_MAX = 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  sfr_text_if.sink               text,
  sfr_result_if.source           result
);

  cfg_t cfg;

  sfr_regs #(
    .PATTERN_MAX(PATTERN_MAX),
    .REPLACE_MAX(REPLACE_MAX)
  ) u_regs (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg    (cfg)
  );

  sfr_engine #(
    .PATTERN_MAX(PATTERN_MAX),
    .REPLACE_MAX(REPLACE_MAX)
  ) u_engine (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .text  (text),
    .result(result)
  );

endmodule

`default_nettype wire
